// ===== rtl/prc_pkg.sv =====
// Package for the package rollback checker: operation codes, status codes,
// compare codes and the magic tag. No dependencies.
package prc_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_OLD   = 2'd1,
		OP_REQ   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_ACCEPT    = 2'd0,
		ST_STALE     = 2'd1,
		ST_MALFORMED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		VC_EQ = 2'd0,
		VC_GT = 2'd1,
		VC_LT = 2'd2
	} vc_t;

	localparam int STORE_DEPTH = 72;
	localparam int STORE_AW    = 7;
	localparam int ID_LO       = 16;
	localparam int REV_LO      = 48;
	localparam int VER_LO      = 56;
	localparam int VER_HI      = 88;
	localparam int ROOT_END    = 63;

	function automatic logic [7:0] magic_byte(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = 8'h50;
			3'd1: r = 8'h4B;
			3'd2: r = 8'h47;
			3'd3: r = 8'h53;
			3'd4: r = 8'h45;
			3'd5: r = 8'h43;
			3'd6: r = 8'h30;
			default: r = 8'h31;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/package_rollback_checker_core.sv =====
// Package rollback checker top level. A request beat passes the stage 1
// register, then the output registers. One byte per cycle when unstalled,
// set by the single read port of the old header store (read in stage 1,
// used in stage 2). Reset clears all control and check state; the header
// store is not cleared and holds anything until an old package writes it.
// Depends on prc_pkg and prc_ram.
module package_rollback_checker_core #(
	parameter int HEADER_BYTES = 96,
	parameter int MAX_BYTES    = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic [1:0] status
);
	localparam int CW = $clog2(MAX_BYTES + 2);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BYTES);
	localparam logic [CW-1:0] HDRC = CW'(HEADER_BYTES);

	// stage 1 register: accepted beat, store read in flight
	logic                          v_s1, req_s1, last_s1, start_s1;
	logic [7:0]                    b_s1;
	logic [CW-1:0]                 pos_s1;
	logic [prc_pkg::STORE_AW-1:0]  ra, ra_s1, rd_a;
	logic [7:0]                    ob;

	// stream state (front end, tracks count and kind)
	logic [CW-1:0] idx_q;
	logic          kind_q;

	logic adv, acc;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign acc = in_valid && adv;

	logic op_old, op_req, op_clr;
	assign op_clr = operation == prc_pkg::OP_CLEAR;
	assign op_old = operation == prc_pkg::OP_OLD;
	assign op_req = operation == prc_pkg::OP_REQ;

	logic          restart;
	logic [CW-1:0] pos;
	assign restart = (idx_q != '0) && (op_req != kind_q);
	assign pos = restart ? '0 : idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			kind_q <= 1'b0;
		end else if (acc) begin
			if (op_clr) idx_q <= '0;
			else if (op_old || op_req) begin
				kind_q <= op_req;
				if (final_byte) idx_q <= '0;
				else if (pos <= MAXC) idx_q <= pos + 1'b1;
				else idx_q <= pos;
			end
		end
	end

	logic [CW-1:0] rpos;
	assign rpos = pos - CW'(prc_pkg::ID_LO);
	assign ra = (pos >= CW'(prc_pkg::ID_LO) && pos < CW'(prc_pkg::VER_HI))
		? rpos[prc_pkg::STORE_AW-1:0] : '0;
	// hold the read address of the waiting stage 1 beat
	assign rd_a = adv ? ra : ra_s1;

	prc_ram #(.WIDTH(8), .DEPTH(prc_pkg::STORE_DEPTH)) u_store (
		.clk(clk),
		.we(acc && op_old && pos >= CW'(prc_pkg::ID_LO) && pos < CW'(prc_pkg::VER_HI)),
		.waddr(ra), .wdata(data_byte), .raddr(rd_a), .rdata(ob)
	);

	logic clr_s1, old_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= acc && operation != prc_pkg::OP_NONE;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= op_req;
			old_s1 <= op_old;
			clr_s1 <= op_clr;
			last_s1 <= final_byte;
			start_s1 <= pos == '0;
			b_s1 <= data_byte;
			pos_s1 <= pos;
			ra_s1 <= ra;
		end
	end

	// stage 2: checks against the stored byte
	logic [31:0] type_q, len_q;
	logic f_magic_q, f_w12_q, f_w92_q, f_id_q, f_rno_q, f_rnz_q, carry_q, rot_q;
	logic [1:0] vc_q [5];
	logic old_present_q, old_ok_q;

	logic [CW-1:0] cnt;
	logic          sat;
	assign cnt = (pos_s1 <= MAXC) ? pos_s1 + 1'b1 : pos_s1;
	assign sat = cnt > MAXC;

	logic [31:0] type_n, len_n;
	logic m_n, w12_n, w92_n, id_n, rno_n, rnz_n, c_n, rot_n;
	logic [1:0] vc_n [5];
	logic [7:0] echo;
	logic [8:0] sum;
	logic [2:0] w;
	logic [CW-1:0] d48;
	logic valid_n, malformed, stale;
	logic [1:0] p8;

	always_comb begin
		type_n = start_s1 ? 32'd0 : type_q;
		len_n  = start_s1 ? 32'd0 : len_q;
		m_n   = !start_s1 && f_magic_q;
		w12_n = !start_s1 && f_w12_q;
		w92_n = !start_s1 && f_w92_q;
		id_n  = !start_s1 && f_id_q;
		rno_n = !start_s1 && f_rno_q;
		rnz_n = !start_s1 && f_rnz_q;
		c_n   = start_s1 || carry_q;
		rot_n = !start_s1 && rot_q;
		for (int i = 0; i < 5; i++) vc_n[i] = start_s1 ? prc_pkg::VC_EQ : vc_q[i];
		echo = b_s1;
		sum = '0;
		d48 = pos_s1 - CW'(prc_pkg::REV_LO);
		w = d48[5:3];
		p8 = pos_s1[1:0];
		if (pos_s1 < 8 && b_s1 != prc_pkg::magic_byte(pos_s1[2:0])) m_n = 1'b1;
		if (pos_s1 >= 8 && pos_s1 < 12) type_n[8*p8 +: 8] = b_s1;
		if (pos_s1 >= 88 && pos_s1 < 92) len_n[8*p8 +: 8] = b_s1;
		if (pos_s1 >= 92 && pos_s1 < 96 && b_s1 != 8'd0) w92_n = 1'b1;
		if (req_s1) begin
			if (pos_s1 >= 12 && pos_s1 < 16 && b_s1 != 8'd0) w12_n = 1'b1;
			if (pos_s1 >= CW'(prc_pkg::ID_LO) && pos_s1 < CW'(prc_pkg::REV_LO)
				&& b_s1 != ob) id_n = 1'b1;
			if (pos_s1 >= CW'(prc_pkg::REV_LO) && pos_s1 < CW'(prc_pkg::VER_LO)) begin
				sum = {1'b0, b_s1} + {8'd0, c_n};
				echo = sum[7:0];
				c_n = sum[8];
				if (b_s1 != 8'hFF) rno_n = 1'b1;
				if (b_s1 != 8'd0) rnz_n = 1'b1;
			end
			if (pos_s1 >= CW'(prc_pkg::REV_LO) && pos_s1 < CW'(prc_pkg::VER_HI)) begin
				if (b_s1 > ob) vc_n[w] = prc_pkg::VC_GT;
				else if (b_s1 < ob) vc_n[w] = prc_pkg::VC_LT;
				if (pos_s1 == CW'(prc_pkg::ROOT_END)) rot_n = vc_n[1] == prc_pkg::VC_GT;
			end
		end
		valid_n = cnt >= HDRC && !sat && !m_n && !w92_n
			&& len_n == 32'(cnt - HDRC) && (type_n == 32'd1 || type_n == 32'd2);
		malformed = !valid_n || type_n != 32'd2 || w12_n || !rno_n
			|| (old_present_q && (!old_ok_q || id_n));
		if (old_present_q)
			stale = vc_n[0] != prc_pkg::VC_EQ || vc_n[1] == prc_pkg::VC_LT
				|| (!rot_n && vc_n[2] == prc_pkg::VC_LT)
				|| (!rot_n && vc_n[3] == prc_pkg::VC_LT)
				|| vc_n[4] == prc_pkg::VC_LT;
		else
			stale = rnz_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= '0; len_q <= '0;
			f_magic_q <= 1'b0; f_w12_q <= 1'b0; f_w92_q <= 1'b0; f_id_q <= 1'b0;
			f_rno_q <= 1'b0; f_rnz_q <= 1'b0; carry_q <= 1'b1; rot_q <= 1'b0;
			for (int i = 0; i < 5; i++) vc_q[i] <= prc_pkg::VC_EQ;
			old_present_q <= 1'b0; old_ok_q <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s1 && req_s1;
			if (v_s1) begin
				if (clr_s1) begin
					old_present_q <= 1'b0; old_ok_q <= 1'b0;
				end else begin
					type_q <= type_n; len_q <= len_n;
					f_magic_q <= m_n || sat; f_w12_q <= w12_n; f_w92_q <= w92_n;
					f_id_q <= id_n; f_rno_q <= rno_n; f_rnz_q <= rnz_n;
					carry_q <= c_n; rot_q <= rot_n;
					for (int i = 0; i < 5; i++) vc_q[i] <= vc_n[i];
					if (old_s1 && start_s1) begin
						old_present_q <= 1'b0; old_ok_q <= 1'b0;
					end
					if (old_s1 && last_s1) begin
						old_present_q <= 1'b1; old_ok_q <= valid_n;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte <= echo;
			out_last <= last_s1;
			status <= !last_s1 ? prc_pkg::ST_ACCEPT
				: malformed ? prc_pkg::ST_MALFORMED
				: stale ? prc_pkg::ST_STALE : prc_pkg::ST_ACCEPT;
		end
	end
endmodule

// ===== rtl/prc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module prc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 72
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
